FILE: src/itdf2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdf2_pkg
// Widths, command codes and control structs of the transposed direct form II
// IIR filter.
// ----------------------------------------------------------------------------
package itdf2_pkg;

	localparam int MAX_ORDER = 8;
	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 32;
	localparam int COEF_FRAC = 24;
	localparam int STATE_W   = SAMPLE_W + COEF_W;
	localparam int ACC_W     = STATE_W + 2;
	localparam int ORDER_W   = 4;
	localparam int IDX_W     = 4;
	localparam int CMD_W     = 2;

	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	localparam logic [ORDER_W-1:0] ORDER_LIMIT = ORDER_W'(MAX_ORDER);

	// control of one delay cell
	typedef struct packed {
		logic load_b;
		logic load_a;
		logic mul_x;
		logic mul_y;
		logic upd;
		logic clr;
		logic last;
		logic active;
	} cell_ctl_t;

	// control of the gain and output stage
	typedef struct packed {
		logic load_b0;
		logic mul_x;
		logic go;
	} head_ctl_t;

endpackage

FILE: src/itdf2_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdf2_if
// Valid/ready channels of the IIR filter: command beats in, samples out.
// ----------------------------------------------------------------------------
interface itdf2_in_if;
	import itdf2_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [CMD_W-1:0]           cmd;
	logic [IDX_W-1:0]           coef_index;
	logic signed [COEF_W-1:0]   coef_value;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source (output valid, cmd, coef_index, coef_value, sample_in, input ready);
	modport sink (input valid, cmd, coef_index, coef_value, sample_in, output ready);
endinterface

interface itdf2_out_if;
	import itdf2_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       saturated;

	modport source (output valid, sample_out, saturated, input ready);
	modport sink (input valid, sample_out, saturated, output ready);
endinterface

FILE: src/iir_transposed_direct_form2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_transposed_direct_form2
// IIR filter in transposed direct form II: a row of delay cells, each with
// its own b and a coefficient, behind a gain and rounding stage.
//
//   port    | kind       | beat carries
//   feed    | sink       | cmd, coef_index, coef_value, sample_in
//   result  | source     | sample_out, saturated (one beat per sample command)
//   cfg_*   | write only | filter_order
//
// Load and clear commands leave the filter ready for the next beat. A sample
// steps through b*x products at the accept edge, output rounding, a*y products,
// then the delay update, during which the next beat is taken. The
// y -> a*y -> update loop sets the sample rate.
// Reset zeroes the coefficients, the delay line and the order.
// A result not taken holds the next sample at its output step.
// ----------------------------------------------------------------------------
module iir_transposed_direct_form2 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [itdf2_pkg::ORDER_W-1:0]  cfg_data,
	itdf2_in_if.sink                       feed,
	itdf2_out_if.source                    result
);
	import itdf2_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_OUT  = 2'd1;
	localparam logic [1:0] PH_MULY = 2'd2;
	localparam logic [1:0] PH_UPD  = 2'd3;

	logic [1:0]                phase_q;
	logic [ORDER_W-1:0]        order_q;
	logic [ORDER_W-1:0]        n_eff;
	logic                      out_valid_q;
	logic                      accept;
	logic                      y_go;
	head_ctl_t                 hctl;
	cell_ctl_t                 cctl [MAX_ORDER];
	logic signed [STATE_W-1:0] s_chain [MAX_ORDER];
	logic signed [STATE_W-1:0] s0;
	logic signed [SAMPLE_W-1:0] y;
	logic                      sat;

	assign feed.ready = (phase_q == PH_IDLE) || (phase_q == PH_UPD);
	assign accept     = feed.valid && feed.ready;
	assign y_go       = (phase_q == PH_OUT) && (!out_valid_q || result.ready);
	assign n_eff      = (order_q > ORDER_LIMIT) ? ORDER_LIMIT : order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= '0;
		end else if (cfg_we) begin
			order_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_IDLE, PH_UPD: begin
					if (accept && feed.cmd == CMD_SAMPLE) begin
						phase_q <= PH_OUT;
					end else begin
						phase_q <= PH_IDLE;
					end
				end
				PH_OUT: begin
					if (y_go) begin
						phase_q <= PH_MULY;
					end
				end
				PH_MULY: begin
					phase_q <= PH_UPD;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (y_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign hctl.load_b0 = accept && feed.cmd == CMD_LOAD_B && feed.coef_index == '0;
	assign hctl.mul_x   = accept && feed.cmd == CMD_SAMPLE;
	assign hctl.go      = y_go;

	assign s0 = (n_eff != '0) ? s_chain[0] : '0;

	itdf2_head u_head (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hctl),
		.coef   (feed.coef_value),
		.x      (feed.sample_in),
		.s0     (s0),
		.y      (y),
		.sat    (sat)
	);

	for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
		logic signed [STATE_W-1:0] s_next;

		if (k == MAX_ORDER - 1) begin : g_end
			assign s_next = '0;
		end else begin : g_mid
			assign s_next = s_chain[k+1];
		end

		// cell k holds s[k], b[k+1] and a[k+1]
		assign cctl[k].load_b = accept && feed.cmd == CMD_LOAD_B
			&& feed.coef_index == IDX_W'(k + 1);
		assign cctl[k].load_a = accept && feed.cmd == CMD_LOAD_A
			&& feed.coef_index == IDX_W'(k + 1);
		assign cctl[k].mul_x  = accept && feed.cmd == CMD_SAMPLE;
		assign cctl[k].mul_y  = phase_q == PH_MULY;
		assign cctl[k].upd    = phase_q == PH_UPD;
		assign cctl[k].clr    = accept && feed.cmd == CMD_CLEAR;
		assign cctl[k].last   = n_eff == ORDER_W'(k + 1);
		assign cctl[k].active = n_eff > ORDER_W'(k);

		itdf2_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cctl[k]),
			.coef   (feed.coef_value),
			.x      (feed.sample_in),
			.y      (y),
			.s_next (s_next),
			.s      (s_chain[k])
		);
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = y;
	assign result.saturated  = sat;

endmodule

FILE: src/itdf2_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdf2_cell
// One delay element with its numerator and denominator coefficient; takes
// the element behind it and hands its own value forward.
// ----------------------------------------------------------------------------
module itdf2_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  itdf2_pkg::cell_ctl_t                 ctl,
	input  logic signed [itdf2_pkg::COEF_W-1:0]   coef,
	input  logic signed [itdf2_pkg::SAMPLE_W-1:0] x,
	input  logic signed [itdf2_pkg::SAMPLE_W-1:0] y,
	input  logic signed [itdf2_pkg::STATE_W-1:0]  s_next,
	output logic signed [itdf2_pkg::STATE_W-1:0]  s
);
	import itdf2_pkg::*;

	localparam logic signed [STATE_W-1:0] S_MAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam logic signed [STATE_W-1:0] S_MIN = {1'b1, {(STATE_W-1){1'b0}}};

	logic signed [COEF_W-1:0]  b_q;
	logic signed [COEF_W-1:0]  a_q;
	logic signed [STATE_W-1:0] s_q;
	logic signed [STATE_W-1:0] bx_s1;
	logic signed [STATE_W-1:0] ay_s2;
	logic signed [STATE_W-1:0] carry;
	logic signed [ACC_W-1:0]   sum;
	logic signed [STATE_W-1:0] sum_sat;

	always_ff @(posedge clk) begin
		if (ctl.mul_x) begin
			bx_s1 <= STATE_W'(b_q) * STATE_W'(x);
		end
		if (ctl.mul_y) begin
			ay_s2 <= STATE_W'(a_q) * STATE_W'(y);
		end
	end

	// the last active element starts from zero
	assign carry = ctl.last ? '0 : s_next;
	assign sum = ACC_W'(carry) + ACC_W'(bx_s1) - ACC_W'(ay_s2);

	always_comb begin
		if (sum[ACC_W-1:STATE_W-1] == '0 || sum[ACC_W-1:STATE_W-1] == '1) begin
			sum_sat = sum[STATE_W-1:0];
		end else if (sum[ACC_W-1]) begin
			sum_sat = S_MIN;
		end else begin
			sum_sat = S_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
			a_q <= '0;
			s_q <= '0;
		end else begin
			if (ctl.load_b) begin
				b_q <= coef;
			end
			if (ctl.load_a) begin
				a_q <= coef;
			end
			if (ctl.clr) begin
				s_q <= '0;
			end else if (ctl.upd && ctl.active) begin
				s_q <= sum_sat;
			end
		end
	end

	assign s = s_q;

endmodule

FILE: src/itdf2_head.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdf2_head
// Direct gain b0*x plus the first delay element, rounded half up and
// saturated to the sample width; holds the output sample.
// ----------------------------------------------------------------------------
module itdf2_head (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  itdf2_pkg::head_ctl_t                 ctl,
	input  logic signed [itdf2_pkg::COEF_W-1:0]   coef,
	input  logic signed [itdf2_pkg::SAMPLE_W-1:0] x,
	input  logic signed [itdf2_pkg::STATE_W-1:0]  s0,
	output logic signed [itdf2_pkg::SAMPLE_W-1:0] y,
	output logic                                 sat
);
	import itdf2_pkg::*;

	localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) <<< (COEF_FRAC - 1);
	localparam logic signed [SAMPLE_W-1:0] Y_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] Y_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam int TOP_LO = COEF_FRAC + SAMPLE_W - 1;

	logic signed [COEF_W-1:0]   b0_q;
	logic signed [STATE_W-1:0]  p0_s1;
	logic signed [ACC_W-1:0]    acc;
	logic signed [SAMPLE_W-1:0] y_d;
	logic                       sat_d;
	logic signed [SAMPLE_W-1:0] y_q;
	logic                       sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= '0;
		end else if (ctl.load_b0) begin
			b0_q <= coef;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_x) begin
			p0_s1 <= STATE_W'(b0_q) * STATE_W'(x);
		end
		if (ctl.go) begin
			y_q   <= y_d;
			sat_q <= sat_d;
		end
	end

	assign acc = ACC_W'(s0) + ACC_W'(p0_s1) + ROUND;

	// floor shift, then clip when the bits above the sample disagree
	always_comb begin
		if (acc[ACC_W-1:TOP_LO] == '0 || acc[ACC_W-1:TOP_LO] == '1) begin
			y_d   = acc[TOP_LO:COEF_FRAC];
			sat_d = 1'b0;
		end else begin
			y_d   = acc[ACC_W-1] ? Y_MIN : Y_MAX;
			sat_d = 1'b1;
		end
	end

	assign y   = y_q;
	assign sat = sat_q;

endmodule

FILE: verif/itdf2_filter_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdf2_filter_check
// Watches the command and sample channels of the IIR filter and keeps its own
// copy of the coefficient stores, the delay line and the order. Every accepted
// sample beat gets a predicted output, and each output beat is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module itdf2_filter_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [itdf2_pkg::ORDER_W-1:0] cfg_data,
	itdf2_in_if                           feed,
	itdf2_out_if                          result,
	output int                            mismatches,
	output int                            outstanding
);
	import itdf2_pkg::*;

	localparam longint SMP_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint SMP_LO = -SMP_HI - 1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       clipped;
	} filtered_t;

	logic signed [COEF_W-1:0] b_coef [MAX_ORDER+1];
	logic signed [COEF_W-1:0] a_coef [MAX_ORDER];
	longint                   taps [MAX_ORDER];
	logic [ORDER_W-1:0]       order_q;
	filtered_t                filtered_q [$];
	int                       err_cnt;

	// delay elements hold STATE_W signed bits and saturate when stored
	function automatic longint clamp_state(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (STATE_W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic filtered_t filter_sample(input logic signed [SAMPLE_W-1:0] x);
		int        n;
		int        k;
		longint    xl;
		longint    acc;
		longint    yl;
		filtered_t r;
		n   = (order_q > ORDER_LIMIT) ? MAX_ORDER : int'(order_q);
		xl  = x;
		acc = (n > 0) ? taps[0] : 0;
		acc = acc + longint'(b_coef[0]) * xl + (longint'(1) <<< (COEF_FRAC - 1));
		// round half up, then clip to the sample range
		yl = acc >>> COEF_FRAC;
		r.clipped = 1'b0;
		if (yl > SMP_HI) begin
			yl = SMP_HI;
			r.clipped = 1'b1;
		end
		if (yl < SMP_LO) begin
			yl = SMP_LO;
			r.clipped = 1'b1;
		end
		r.value = yl[SAMPLE_W-1:0];
		// feedback uses the clipped output
		for (k = 0; k < n - 1; k++)
			taps[k] = clamp_state(taps[k+1] + longint'(b_coef[k+1]) * xl
				- longint'(a_coef[k]) * yl);
		if (n > 0)
			taps[n-1] = clamp_state(longint'(b_coef[n]) * xl - longint'(a_coef[n-1]) * yl);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		filtered_t want;
		int        i;
		if (!arst_n) begin
			for (i = 0; i <= MAX_ORDER; i++)
				b_coef[i] = '0;
			for (i = 0; i < MAX_ORDER; i++) begin
				a_coef[i] = '0;
				taps[i]   = 0;
			end
			order_q = '0;
			filtered_q.delete();
			err_cnt = 0;
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (filtered_q.size() == 0) begin
					err_cnt++;
					$display("%0t: output beat with none expected, expected nothing, got %0d sat %0b",
						$time, result.sample_out, result.saturated);
				end else begin
					want = filtered_q.pop_front();
					if (result.sample_out !== want.value) begin
						err_cnt++;
						$display("%0t: sample_out expected %0d got %0d",
							$time, want.value, result.sample_out);
					end
					if (result.saturated !== want.clipped) begin
						err_cnt++;
						$display("%0t: saturated expected %0b got %0b",
							$time, want.clipped, result.saturated);
					end
				end
			end
			if (cfg_we)
				order_q = cfg_data;
			if (feed.valid && feed.ready) begin
				case (feed.cmd)
					CMD_SAMPLE: begin
						filtered_q.push_back(filter_sample(feed.sample_in));
					end
					CMD_LOAD_B: begin
						if (feed.coef_index <= ORDER_LIMIT)
							b_coef[feed.coef_index] = feed.coef_value;
					end
					CMD_LOAD_A: begin
						if (feed.coef_index >= 1 && feed.coef_index <= ORDER_LIMIT)
							a_coef[feed.coef_index - 1] = feed.coef_value;
					end
					CMD_CLEAR: begin
						for (i = 0; i < MAX_ORDER; i++)
							taps[i] = 0;
					end
				endcase
			end
			outstanding <= filtered_q.size();
			mismatches  <= err_cnt;
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the IIR filter with a directed set of corner beats and then with
// bursts of coefficient loads, clears and samples under three idle patterns,
// including a long output stall and a full drain. The checker beside the
// filter predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import itdf2_pkg::*;

	localparam int RX_HOLD     = 300;
	localparam int PHASE_ITEMS = 345;

	localparam logic signed [SAMPLE_W-1:0] X_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] X_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [COEF_W-1:0]   C_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0]   C_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic signed [COEF_W-1:0]   C_ONE = COEF_W'(1) << COEF_FRAC;
	localparam logic signed [COEF_W-1:0]   C_HALF = COEF_W'(1) << (COEF_FRAC - 1);

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [ORDER_W-1:0] cfg_data;
	int                 mismatches;
	int                 outstanding;
	int                 send_idle;
	int                 recv_idle;
	int                 cur_order;
	bit                 hold_req;

	itdf2_in_if  feed_ch ();
	itdf2_out_if res_ch ();

	iir_transposed_direct_form2 uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.feed     (feed_ch),
		.result   (res_ch)
	);

	itdf2_filter_check filter_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.feed        (feed_ch),
		.result      (res_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// output side: random backpressure, or a long hold when asked
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (RX_HOLD) begin
					res_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_beat(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
			input logic signed [COEF_W-1:0] val, input logic signed [SAMPLE_W-1:0] smp);
		while ($urandom_range(99) < send_idle) begin
			feed_ch.valid <= 1'b0;
			@(posedge clk);
		end
		feed_ch.valid      <= 1'b1;
		feed_ch.cmd        <= c;
		feed_ch.coef_index <= idx;
		feed_ch.coef_value <= val;
		feed_ch.sample_in  <= smp;
		do @(posedge clk); while (!feed_ch.ready);
	endtask

	// wait for every pending output, then let the delay update settle
	task automatic drain();
		feed_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_order(input logic [ORDER_W-1:0] ord);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= ord;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_order = ord;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return X_MAX;
			1: return X_MIN;
			2, 3, 4: return SAMPLE_W'($urandom_range(2000)) - SAMPLE_W'(1000);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef(input bit wild, input int span);
		if (wild) return $urandom;
		return COEF_W'($urandom_range(2 * span)) - COEF_W'(span);
	endfunction

	initial begin : stim
		int phase;
		int burst;
		int nsamp;
		int n;
		int items;
		int i;
		int j;
		bit wild;
		send_idle = 21;
		recv_idle = 47;
		cur_order = 0;
		hold_req  = 1'b0;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_data           <= '0;
		feed_ch.valid      <= 1'b0;
		feed_ch.cmd        <= CMD_SAMPLE;
		feed_ch.coef_index <= '0;
		feed_ch.coef_value <= '0;
		feed_ch.sample_in  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pure gain corners: zero gain, unity, clipping both ways, rounding
		send_beat(CMD_SAMPLE, '0, '0, SAMPLE_W'(123));
		send_beat(CMD_LOAD_B, IDX_W'(0), C_ONE, '0);
		send_beat(CMD_SAMPLE, '0, '0, X_MAX);
		send_beat(CMD_SAMPLE, '0, '0, X_MIN);
		send_beat(CMD_LOAD_B, IDX_W'(0), C_MAX, '0);
		send_beat(CMD_SAMPLE, '0, '0, X_MAX);
		send_beat(CMD_SAMPLE, '0, '0, X_MIN);
		send_beat(CMD_LOAD_B, IDX_W'(0), C_MIN, '0);
		send_beat(CMD_SAMPLE, '0, '0, X_MIN);
		send_beat(CMD_LOAD_B, IDX_W'(0), C_HALF, '0);
		send_beat(CMD_SAMPLE, '0, '0, SAMPLE_W'(1));
		send_beat(CMD_SAMPLE, '0, '0, -SAMPLE_W'(1));
		// out-of-range coefficient positions are dropped
		send_beat(CMD_LOAD_B, IDX_W'(9), 32'h5A5A_5A5A, '0);
		send_beat(CMD_LOAD_B, IDX_W'(15), -COEF_W'(1), '0);
		send_beat(CMD_LOAD_A, IDX_W'(0), -COEF_W'(1), '0);
		send_beat(CMD_LOAD_A, IDX_W'(15), C_MAX, '0);
		// order above the maximum, extreme last tap, state saturation
		set_order(ORDER_W'(15));
		send_beat(CMD_LOAD_A, IDX_W'(MAX_ORDER), C_MIN, '0);
		send_beat(CMD_LOAD_B, IDX_W'(MAX_ORDER), C_MAX, '0);
		send_beat(CMD_SAMPLE, '0, '0, X_MAX);
		send_beat(CMD_SAMPLE, '0, '0, X_MAX);
		send_beat(CMD_SAMPLE, '0, '0, X_MIN);
		send_beat(CMD_CLEAR, '0, '0, '0);
		send_beat(CMD_SAMPLE, '0, '0, SAMPLE_W'(5));

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle = 21; recv_idle = 47; end
				1: begin send_idle = 47; recv_idle = 21; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			items = 0;
			burst = 0;
			while (items < PHASE_ITEMS) begin
				if (burst == 0 || $urandom_range(99) < 60) begin
					case ($urandom_range(19))
						0: set_order('0);
						1: set_order(ORDER_W'($urandom_range(9, 15)));
						default: set_order(ORDER_W'($urandom_range(1, MAX_ORDER)));
					endcase
				end
				n = (cur_order > MAX_ORDER) ? MAX_ORDER : cur_order;
				wild = ($urandom_range(9) == 0);
				// small a values keep the filter stable most of the time
				for (i = 0; i <= n; i++)
					send_beat(CMD_LOAD_B, IDX_W'(i), rand_coef(wild, 1 << 23), rand_sample());
				for (i = 1; i <= n; i++)
					send_beat(CMD_LOAD_A, IDX_W'(i), rand_coef(wild, (1 << COEF_FRAC) / (n + 1)),
						rand_sample());
				items += 2 * n + 1;
				if ($urandom_range(9) < 8) begin
					send_beat(CMD_CLEAR, IDX_W'($urandom), $urandom, rand_sample());
					items++;
				end
				nsamp = $urandom_range(10, 40);
				if (phase == 0 && burst == 2)
					hold_req = 1'b1;
				for (j = 0; j < nsamp; j++) begin
					if (phase == 1 && burst == 1 && j == nsamp / 2)
						drain();
					if ($urandom_range(19) == 0)
						send_beat(CMD_W'($urandom_range(3)), IDX_W'($urandom_range(15)), $urandom,
							rand_sample());
					send_beat(CMD_SAMPLE, IDX_W'($urandom), $urandom, rand_sample());
					items++;
				end
				burst++;
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
src/itdf2_pkg.sv
src/itdf2_if.sv
src/itdf2_cell.sv
src/itdf2_head.sv
src/iir_transposed_direct_form2.sv
verif/itdf2_filter_check.sv
verif/tb_top.sv
